### rtl/dka_pkg.sv
// shared types and constants for the difference key alpha block
`timescale 1ns / 1ps
`default_nettype none
package dka_pkg;

  localparam int unsigned CW = 16;           // component width
  localparam int unsigned SQ_STEPS = 17;     // root bits of a 34-bit sum of squares
  localparam int unsigned DIV_STEPS = 16;    // quotient bits of the ramp

  localparam logic [15:0] FULL_SCALE = 16'hffff;
  localparam logic [15:0] THRESH_RESET = 16'd6554;

  // luma weights in q16, summing to 65536
  localparam logic [15:0] LUMA_KR = 16'd19595;
  localparam logic [15:0] LUMA_KG = 16'd38470;
  localparam logic [15:0] LUMA_KB = 16'd7471;
  localparam logic [32:0] LUMA_ROUND = 33'd32768;

  // config register indexes
  localparam logic [7:0] REG_THRESHOLD = 8'd0;
  localparam logic [7:0] REG_RAMP_WIDTH = 8'd1;
  localparam logic [7:0] REG_USE_VALUE = 8'd2;
  localparam logic [7:0] REG_PIXEL_FORMAT = 8'd3;

  // key class after the compare stage
  localparam logic [1:0] CLS_ZERO = 2'd0;
  localparam logic [1:0] CLS_FULL = 2'd1;
  localparam logic [1:0] CLS_RAMP = 2'd2;

  // sideband carried beside the square root
  typedef struct packed {
    logic        use_v;
    logic        in_win;
    logic [16:0] ve;
    logic [15:0] ta;
  } side_t;

  // sideband carried beside the divider
  typedef struct packed {
    logic [1:0]  cls;
    logic [15:0] ta;
  } dside_t;

endpackage
`default_nettype wire

### rtl/dka_front.sv
// front stages: differences, luma, squares and the value window
`timescale 1ns / 1ps
`default_nettype none
module dka_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        ce,
  input  wire logic        in_valid,
  input  wire logic [15:0] t0,
  input  wire logic [15:0] t1,
  input  wire logic [15:0] t2,
  input  wire logic [15:0] ta,
  input  wire logic [15:0] b0,
  input  wire logic [15:0] b1,
  input  wire logic [15:0] b2,
  input  wire logic        use_value,
  input  wire logic        pixel_format,
  input  wire logic [15:0] threshold,
  output logic             out_valid,
  output logic [33:0]      sum_sq,
  output dka_pkg::side_t   side
);
  import dka_pkg::*;

  // stage 1
  logic        v1;
  logic [15:0] d0, d1, d2, tc1, bc1, ta1;
  logic [31:0] lt0, lt1, lt2, lb0, lb1, lb2;
  // stage 2
  logic        v2;
  logic [31:0] sq0, sq1, sq2;
  logic [15:0] ty, by, tc2, bc2, ta2;

  logic [32:0] tsum, bsum;
  logic [15:0] tv, bv;
  logic signed [17:0] tvs, lo, hi, elo, ehi;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d0 <= (t0 > b0) ? t0 - b0 : b0 - t0;
      d1 <= (t1 > b1) ? t1 - b1 : b1 - t1;
      d2 <= (t2 > b2) ? t2 - b2 : b2 - t2;
      lt0 <= t0 * LUMA_KR;
      lt1 <= t1 * LUMA_KG;
      lt2 <= t2 * LUMA_KB;
      lb0 <= b0 * LUMA_KR;
      lb1 <= b1 * LUMA_KG;
      lb2 <= b2 * LUMA_KB;
      tc1 <= t0;
      bc1 <= b0;
      ta1 <= ta;
    end
  end

  always_comb begin
    tsum = {1'b0, lt0} + {1'b0, lt1} + {1'b0, lt2} + LUMA_ROUND;
    bsum = {1'b0, lb0} + {1'b0, lb1} + {1'b0, lb2} + LUMA_ROUND;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sq0 <= d0 * d0;
      sq1 <= d1 * d1;
      sq2 <= d2 * d2;
      ty <= tsum[31:16];
      by <= bsum[31:16];
      tc2 <= tc1;
      bc2 <= bc1;
      ta2 <= ta1;
    end
  end

  // value window around the background value
  always_comb begin
    tv = pixel_format ? tc2 : ty;
    bv = pixel_format ? bc2 : by;
    tvs = signed'({2'b00, tv});
    lo = signed'({2'b00, bv}) - signed'({2'b00, threshold});
    hi = signed'({2'b00, bv}) + signed'({2'b00, threshold});
    elo = lo - tvs;
    ehi = tvs - hi;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sum_sq <= {2'b00, sq0} + {2'b00, sq1} + {2'b00, sq2};
      side.use_v <= use_value;
      side.in_win <= (tvs >= lo) && (tvs < hi);
      side.ve <= (tvs < lo) ? elo[16:0] : ehi[16:0];
      side.ta <= ta2;
    end
  end

endmodule
`default_nettype wire

### rtl/dka_sqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module dka_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        ce,
  input  wire logic        in_valid,
  input  wire logic [33:0] s,
  input  dka_pkg::side_t   side_in,
  output logic             out_valid,
  output logic [16:0]      root,
  output logic [19:0]      rem,
  output dka_pkg::side_t   side_out
);
  import dka_pkg::*;

  logic        vr    [SQ_STEPS];
  logic [33:0] sr    [SQ_STEPS];
  logic [16:0] rootr [SQ_STEPS];
  logic [19:0] remr  [SQ_STEPS];
  side_t       sider [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam int P = SQ_STEPS - 1 - k;
    logic        pv;
    logic [33:0] ps;
    logic [16:0] proot;
    logic [19:0] prem, rsh, trial;
    side_t       pside;

    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign ps = s;
      assign proot = '0;
      assign prem = '0;
      assign pside = side_in;
    end else begin : g_next
      assign pv = vr[k-1];
      assign ps = sr[k-1];
      assign proot = rootr[k-1];
      assign prem = remr[k-1];
      assign pside = sider[k-1];
    end

    assign rsh = {prem[17:0], ps[2*P+1:2*P]};
    assign trial = {1'b0, proot, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[k] <= 1'b0;
      end else if (ce) begin
        vr[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        sr[k] <= ps;
        sider[k] <= pside;
        if (rsh >= trial) begin
          remr[k] <= rsh - trial;
          rootr[k] <= {proot[15:0], 1'b1};
        end else begin
          remr[k] <= rsh;
          rootr[k] <= {proot[15:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vr[SQ_STEPS-1];
  assign root = rootr[SQ_STEPS-1];
  assign rem = remr[SQ_STEPS-1];
  assign side_out = sider[SQ_STEPS-1];

endmodule
`default_nettype wire

### rtl/dka_div.sv
// pipelined restoring divider for the ramp, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module dka_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        ce,
  input  wire logic        in_valid,
  input  wire logic [15:0] e,
  input  wire logic [15:0] width,
  input  dka_pkg::dside_t  side_in,
  output logic             out_valid,
  output logic [15:0]      q,
  output dka_pkg::dside_t  side_out
);
  import dka_pkg::*;

  logic [31:0] num;
  logic        vr   [DIV_STEPS];
  logic [15:0] remr [DIV_STEPS];
  logic [15:0] lor  [DIV_STEPS];
  logic [15:0] qr   [DIV_STEPS];
  dside_t      sider[DIV_STEPS];

  // e * 65535 as (e << 16) - e
  assign num = {e, 16'h0000} - {16'h0000, e};

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic        pv;
    logic [15:0] prem, plo, pq;
    logic [16:0] r17;
    dside_t      pside;

    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign prem = num[31:16];
      assign plo = num[15:0];
      assign pq = '0;
      assign pside = side_in;
    end else begin : g_next
      assign pv = vr[k-1];
      assign prem = remr[k-1];
      assign plo = lor[k-1];
      assign pq = qr[k-1];
      assign pside = sider[k-1];
    end

    assign r17 = {prem, plo[DIV_STEPS-1-k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[k] <= 1'b0;
      end else if (ce) begin
        vr[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        lor[k] <= plo;
        sider[k] <= pside;
        if (r17 >= {1'b0, width}) begin
          remr[k] <= 16'(r17 - {1'b0, width});
          qr[k] <= {pq[14:0], 1'b1};
        end else begin
          remr[k] <= r17[15:0];
          qr[k] <= {pq[14:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vr[DIV_STEPS-1];
  assign q = qr[DIV_STEPS-1];
  assign side_out = sider[DIV_STEPS-1];

endmodule
`default_nettype wire

### rtl/difference_key_alpha.sv
// top level of the difference key alpha pipeline
// throughput: one word per cycle while out_ready stays high
// the 17-stage square root and 16-stage ramp divider set the depth
// a stalled output word holds the whole pipeline; nothing is dropped
// rst (synchronous) empties the pipeline and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none
module difference_key_alpha (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] top_c0,
  input  wire logic [15:0] top_c1,
  input  wire logic [15:0] top_c2,
  input  wire logic [15:0] top_alpha,
  input  wire logic [15:0] bottom_c0,
  input  wire logic [15:0] bottom_c1,
  input  wire logic [15:0] bottom_c2,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      key_alpha,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import dka_pkg::*;

  // config registers
  logic [15:0] key_threshold;
  logic [15:0] ramp_width;
  logic        use_value;
  logic        pixel_format;

  // one enable for every stage: advance unless the output word is stuck
  logic ce;
  assign ce = !out_valid || out_ready;
  assign in_ready = ce;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_threshold <= THRESH_RESET;
      ramp_width <= '0;
      use_value <= 1'b0;
      pixel_format <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD:    key_threshold <= cfg_data;
        REG_RAMP_WIDTH:   ramp_width <= cfg_data;
        REG_USE_VALUE:    use_value <= cfg_data[0];
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // front: differences, luma, squares, value window
  logic        fv;
  logic [33:0] sum_sq;
  side_t       fside;

  dka_front u_front (
    .clk          (clk),
    .rst          (rst),
    .ce           (ce),
    .in_valid     (in_valid),
    .t0           (top_c0),
    .t1           (top_c1),
    .t2           (top_c2),
    .ta           (top_alpha),
    .b0           (bottom_c0),
    .b1           (bottom_c1),
    .b2           (bottom_c2),
    .use_value    (use_value),
    .pixel_format (pixel_format),
    .threshold    (key_threshold),
    .out_valid    (fv),
    .sum_sq       (sum_sq),
    .side         (fside)
  );

  // colour cube distance
  logic        sv;
  logic [16:0] root;
  logic [19:0] rem;
  side_t       sside;

  dka_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (fv),
    .s         (sum_sq),
    .side_in   (fside),
    .out_valid (sv),
    .root      (root),
    .rem       (rem),
    .side_out  (sside)
  );

  // classify: below threshold, on the ramp, or past it
  logic [17:0] cube_dist, ecube;
  logic [1:0]  cls_next;
  logic [15:0] e_next;
  logic        cv;
  logic [15:0] ce_e;
  dside_t      cside;

  always_comb begin
    // round half up: bump when s - r^2 exceeds r
    cube_dist = {1'b0, root} + {17'b0, (rem > {3'b000, root})};
    ecube = cube_dist - {2'b00, key_threshold};
    if (sside.use_v) begin
      e_next = sside.ve[15:0];
      if (sside.in_win) begin
        cls_next = CLS_ZERO;
      end else if (sside.ve < {1'b0, ramp_width}) begin
        cls_next = CLS_RAMP;
      end else begin
        cls_next = CLS_FULL;
      end
    end else begin
      e_next = ecube[15:0];
      if (cube_dist < {2'b00, key_threshold}) begin
        cls_next = CLS_ZERO;
      end else if (ecube < {2'b00, ramp_width}) begin
        cls_next = CLS_RAMP;
      end else begin
        cls_next = CLS_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else if (ce) begin
      cv <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ce_e <= e_next;
      cside.cls <= cls_next;
      cside.ta <= sside.ta;
    end
  end

  // ramp: e * 65535 / ramp_width
  logic        dv;
  logic [15:0] quo;
  dside_t      dside;

  dka_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (cv),
    .e         (ce_e),
    .width     (ramp_width),
    .side_in   (cside),
    .out_valid (dv),
    .q         (quo),
    .side_out  (dside)
  );

  // output register: key limited by the incoming alpha
  logic [15:0] key;
  logic [15:0] key_alpha_next;

  always_comb begin
    case (dside.cls)
      CLS_ZERO: key = '0;
      CLS_RAMP: key = quo;
      default:  key = FULL_SCALE;
    endcase
    key_alpha_next = (key < dside.ta) ? key : dside.ta;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      key_alpha <= key_alpha_next;
    end
  end

endmodule
`default_nettype wire

### rtl/dka_checker.sv
// port-level checks for the difference key alpha block, bound to the top
`timescale 1ns / 1ps
`default_nettype none
module dka_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] key_alpha
);

  // a stalled word holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_alpha))
    else $error("output word changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word present after reset");

  // an empty output stage never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // a word leaving frees the pipeline for a new one
  a_ready_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> in_ready)
    else $error("input blocked while output drains");

endmodule

bind difference_key_alpha dka_checker u_dka_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .key_alpha (key_alpha)
);
`default_nettype wire
